[hw/rtl/mtis_pkg.sv]
`timescale 1ns / 1ps

package mtis_pkg;

    // Default geometry of the table
    localparam int TABLE_DEPTH_DEFAULT = 1024;
    localparam int VALUE_WIDTH_DEFAULT = 32;

    // Configuration port
    localparam int APB_ADDR_WIDTH = 3;
    localparam int APB_DATA_WIDTH = 32;
    localparam int ENTRIES_WIDTH  = 11;
    localparam logic [ENTRIES_WIDTH-1:0] ENTRIES_RESET = 11'd2;

    // Register index (paddr bit 2 selects the word)
    localparam logic REG_ENTRIES_IN_USE = 1'b0;

    // Item operation codes
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Widths of the output interval start and of the input slot
    localparam int START_WIDTH = 10;
    localparam int SLOT_WIDTH  = 10;

    // Search sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ENDS_LO,
        ST_ENDS_HI,
        ST_ROUND,
        ST_DIV_SETUP,
        ST_DIV,
        ST_CLAMP,
        ST_PROBE_A,
        ST_PROBE_B,
        ST_DECIDE,
        ST_FINISH
    } state_t;

endpackage

[hw/rtl/mtis_ram.sv]
`timescale 1ns / 1ps

// Simple dual-port RAM: one write port, one read port, registered read data
module mtis_ram #(
    parameter int DATA_WIDTH = 32,
    parameter int DEPTH      = 1024,
    localparam int ADDR_WIDTH = $clog2(DEPTH)
) (
    input  logic                  clk,
    input  logic                  wr_en,
    input  logic [ADDR_WIDTH-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0] wr_data,
    input  logic [ADDR_WIDTH-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0] rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

[hw/rtl/monotonic_table_interval_search_top.sv]
`timescale 1ns / 1ps

// Interval search over a monotonic table held in one block RAM.
// Input channel (s_*): operation 0 writes s_entry_value to table slot s_entry_slot
// and yields no result; operation 1 looks up s_query_value and
// yields one item on the result channel (m_*): the lower index of the bracketing
// interval among the first entries_in_use entries (0 or size-1 when outside).
// entries_in_use is set through the APB port at address 0; the user must write it
// only while the block is idle, which the block itself does not enforce. A query
// reads both table ends, then runs one round per probe step: a bit-per-cycle
// divider for the interpolation probe plus two table reads, with the divider
// skipped when the end values are equal or the quotient saturates; the result
// register then loads once it is free.
// One item is worked on at a time; the next item is taken while a finished result
// still waits in the output register, and a query that completes while that
// register is full holds until the receiver takes the waiting result.
// Reset (synchronous, aresetn low) returns the sequencer to idle, drops m_valid
// and sets entries_in_use to 2; table contents are undefined until loaded.
module monotonic_table_interval_search_top #(
    parameter int TABLE_DEPTH = mtis_pkg::TABLE_DEPTH_DEFAULT,
    parameter int VALUE_WIDTH = mtis_pkg::VALUE_WIDTH_DEFAULT
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,

    // APB configuration port
    input  logic                                 psel,
    input  logic                                 penable,
    input  logic                                 pwrite,
    input  logic [mtis_pkg::APB_ADDR_WIDTH-1:0]  paddr,
    input  logic [mtis_pkg::APB_DATA_WIDTH-1:0]  pwdata,
    output logic [mtis_pkg::APB_DATA_WIDTH-1:0]  prdata,
    output logic                                 pready,

    // Input items
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic                                 s_operation,
    input  logic [mtis_pkg::SLOT_WIDTH-1:0]      s_entry_slot,
    input  logic signed [31:0]                   s_entry_value,
    input  logic signed [31:0]                   s_query_value,

    // Result items
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [mtis_pkg::START_WIDTH-1:0]     m_interval_start
);

    localparam int VW    = VALUE_WIDTH;
    localparam int IW    = $clog2(TABLE_DEPTH);
    localparam int NW    = VW + IW + 3;
    localparam int CNTW  = $clog2(IW + 1);
    localparam int CW    = (IW + 1 > mtis_pkg::ENTRIES_WIDTH) ? IW + 1
                                                              : mtis_pkg::ENTRIES_WIDTH;
    localparam int SLW   = ((IW > mtis_pkg::SLOT_WIDTH) ? IW : mtis_pkg::SLOT_WIDTH) + 1;
    localparam int OW    = (IW > mtis_pkg::START_WIDTH) ? IW : mtis_pkg::START_WIDTH;

    // a lies before b in the table's direction
    function automatic logic precedes(input logic asc,
                                      input logic signed [VW-1:0] a,
                                      input logic signed [VW-1:0] b);
        precedes = asc ? (a < b) : (a > b);
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    mtis_pkg::state_t state_reg, state_next;
    logic                                  m_valid_reg, m_valid_next;
    logic [mtis_pkg::START_WIDTH-1:0]      out_reg, out_next;
    logic [mtis_pkg::ENTRIES_WIDTH-1:0]    entries_reg, entries_next;

    logic signed [VW-1:0]  v_reg, v_next;
    logic signed [VW-1:0]  al_reg, al_next;
    logic signed [VW-1:0]  ar_reg, ar_next;
    logic signed [VW-1:0]  vlo_reg, vlo_next;
    logic [IW-1:0]         li_reg, li_next;
    logic [IW-1:0]         ri_reg, ri_next;
    logic [IW-1:0]         mib_reg, mib_next;
    logic [IW-1:0]         mir_reg, mir_next;
    logic                  asc_reg, asc_next;
    logic signed [NW-1:0]  num_reg, num_next;
    logic signed [VW:0]    den_reg, den_next;
    logic [NW-1:0]         rem_reg, rem_next;
    logic [NW-1:0]         dsh_reg, dsh_next;
    logic [IW-1:0]         qmag_reg, qmag_next;
    logic                  sat_reg, sat_next;
    logic                  qneg_reg, qneg_next;
    logic [CNTW-1:0]       cnt_reg, cnt_next;

    // ------------------------------------------------------------------
    // Input conversion: low VALUE_WIDTH bits, or the 32 input bits zero-extended when wider, as two's complement
    // ------------------------------------------------------------------
    logic signed [VW-1:0] entry_val_w, query_val_w;

    if (VALUE_WIDTH <= 32) begin : g_narrow
        assign entry_val_w = s_entry_value[VW-1:0];
        assign query_val_w = s_query_value[VW-1:0];
    end else begin : g_wide
        assign entry_val_w = {{(VW-32){1'b0}}, s_entry_value};
        assign query_val_w = {{(VW-32){1'b0}}, s_query_value};
    end

    // ------------------------------------------------------------------
    // Table memory
    // ------------------------------------------------------------------
    logic              ram_we;
    logic [IW-1:0]     ram_waddr, ram_raddr;
    logic [VW-1:0]     ram_rdata_u;
    logic signed [VW-1:0] ram_rdata;
    logic [SLW-1:0]    slot_ext;
    logic              in_accept;

    assign in_accept = s_valid && s_ready;
    assign slot_ext  = SLW'(s_entry_slot);
    assign ram_waddr = slot_ext[IW-1:0];
    assign ram_we    = in_accept && (s_operation == mtis_pkg::OP_LOAD)
                       && (slot_ext < SLW'(TABLE_DEPTH));
    assign ram_rdata = ram_rdata_u;

    mtis_ram #(
        .DATA_WIDTH (VW),
        .DEPTH      (TABLE_DEPTH)
    ) u_table (
        .clk     (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (entry_val_w),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata_u)
    );

    // ------------------------------------------------------------------
    // Configuration port
    // ------------------------------------------------------------------
    logic cfg_wr;
    logic reg_hit;

    assign pready  = 1'b1;
    assign reg_hit = (paddr[2] == mtis_pkg::REG_ENTRIES_IN_USE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign prdata  = reg_hit ? mtis_pkg::APB_DATA_WIDTH'(entries_reg)
                             : '0;

    // Clamp of entries_in_use to [2, TABLE_DEPTH], giving the upper bound
    logic [CW-1:0] n_ext, n_clamp;
    logic [IW-1:0] ri_init;

    assign n_ext   = CW'(entries_reg);
    assign n_clamp = (n_ext < CW'(2)) ? CW'(2)
                   : (n_ext > CW'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH) : n_ext;
    assign ri_init = IW'(n_clamp - CW'(1));

    // ------------------------------------------------------------------
    // Datapath helpers
    // ------------------------------------------------------------------
    logic [IW:0]           mid_sum;
    logic [IW-1:0]         mid_w;
    logic [IW-1:0]         dl_w;
    logic signed [IW:0]    dl_s;
    logic signed [VW+1:0]  diff_w;
    logic signed [NW-1:0]  prod_w;
    logic [NW-1:0]         num_mag;
    logic [VW:0]           den_mag;
    logic [NW-1:0]         den_ext;
    logic                  div_take;
    logic [IW-1:0]         qm_w;
    logic signed [IW+1:0]  q_s;
    logic signed [IW+2:0]  s_val, lo_b, hi_b, s_clamp;
    logic [IW-1:0]         p_lo, p_hi;
    logic                  out_free;

    // Binary midpoint
    assign mid_sum = {1'b0, li_reg} + {1'b0, ri_reg};
    assign mid_w   = mid_sum[IW:1];

    // Interpolation numerator: (2v - (al + ar)) * (ri - li)
    assign dl_w   = ri_reg - li_reg;
    assign dl_s   = {1'b0, dl_w};
    assign diff_w = $signed({v_reg[VW-1], v_reg, 1'b0})
                  - ($signed({{2{al_reg[VW-1]}}, al_reg})
                  +  $signed({{2{ar_reg[VW-1]}}, ar_reg}));
    assign prod_w = diff_w * dl_s;

    // Magnitudes for the restoring divider
    assign num_mag = num_reg[NW-1] ? NW'(-num_reg) : NW'(num_reg);
    assign den_mag = den_reg[VW] ? VW'(0) - den_reg : den_reg;
    assign den_ext = NW'(den_mag);
    assign div_take = (rem_reg >= dsh_reg);

    // Signed quotient, offset, and clamp to [2*li, 2*ri]
    assign qm_w    = sat_reg ? {IW{1'b1}} : qmag_reg;
    assign q_s     = qneg_reg ? -$signed({2'b00, qm_w}) : $signed({2'b00, qm_w});
    assign s_val   = {q_s[IW+1], q_s} + {3'b000, li_reg} + {3'b000, ri_reg};
    assign lo_b    = {2'b00, li_reg, 1'b0};
    assign hi_b    = {2'b00, ri_reg, 1'b0};
    assign s_clamp = (s_val < lo_b) ? lo_b : (s_val > hi_b) ? hi_b : s_val;

    // Probe pair ordered by index
    assign p_lo = (mib_reg < mir_reg) ? mib_reg : mir_reg;
    assign p_hi = (mib_reg < mir_reg) ? mir_reg : mib_reg;

    assign out_free = !m_valid_reg || m_ready;

    // ------------------------------------------------------------------
    // Sequencer: next state and datapath
    // ------------------------------------------------------------------
    logic [OW-1:0] li_out;
    assign li_out = OW'(li_reg);

    always_comb begin
        state_next   = state_reg;
        m_valid_next = m_valid_reg;
        out_next     = out_reg;
        entries_next = entries_reg;
        v_next       = v_reg;
        al_next      = al_reg;
        ar_next      = ar_reg;
        vlo_next     = vlo_reg;
        li_next      = li_reg;
        ri_next      = ri_reg;
        mib_next     = mib_reg;
        mir_next     = mir_reg;
        asc_next     = asc_reg;
        num_next     = num_reg;
        den_next     = den_reg;
        rem_next     = rem_reg;
        dsh_next     = dsh_reg;
        qmag_next    = qmag_reg;
        sat_next     = sat_reg;
        qneg_next    = qneg_reg;
        cnt_next     = cnt_reg;
        ram_raddr    = li_reg;
        s_ready      = 1'b0;

        if (cfg_wr && reg_hit) begin
            entries_next = pwdata[mtis_pkg::ENTRIES_WIDTH-1:0];
        end

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            mtis_pkg::ST_IDLE: begin
                s_ready   = 1'b1;
                ram_raddr = '0;
                if (s_valid && (s_operation == mtis_pkg::OP_QUERY)) begin
                    v_next     = query_val_w;
                    li_next    = '0;
                    ri_next    = ri_init;
                    state_next = mtis_pkg::ST_ENDS_LO;
                end
            end

            // first entry arrives, fetch last used entry
            mtis_pkg::ST_ENDS_LO: begin
                al_next    = ram_rdata;
                ram_raddr  = ri_reg;
                state_next = mtis_pkg::ST_ENDS_HI;
            end

            // direction and out-of-range checks
            mtis_pkg::ST_ENDS_HI: begin
                ar_next  = ram_rdata;
                asc_next = (ram_rdata > al_reg);
                if (precedes(ram_rdata > al_reg, v_reg, al_reg)) begin
                    state_next = mtis_pkg::ST_FINISH;
                end else if (precedes(ram_rdata > al_reg, ram_rdata, v_reg)) begin
                    li_next    = ri_reg;
                    state_next = mtis_pkg::ST_FINISH;
                end else if (dl_w > IW'(1)) begin
                    state_next = mtis_pkg::ST_ROUND;
                end else begin
                    state_next = mtis_pkg::ST_FINISH;
                end
            end

            // midpoint, and either the flat-ends shortcut or the numerator
            mtis_pkg::ST_ROUND: begin
                mib_next = mid_w;
                if (ar_reg == al_reg) begin
                    mir_next   = mid_w;
                    state_next = mtis_pkg::ST_PROBE_A;
                end else begin
                    num_next   = prod_w;
                    den_next   = $signed({ar_reg[VW-1], ar_reg})
                               - $signed({al_reg[VW-1], al_reg});
                    state_next = mtis_pkg::ST_DIV_SETUP;
                end
            end

            // quotient only needs IW bits; larger ones saturate and get clamped
            mtis_pkg::ST_DIV_SETUP: begin
                rem_next  = num_mag;
                dsh_next  = den_ext << (IW - 1);
                sat_next  = (num_mag >= (den_ext << IW));
                qneg_next = num_reg[NW-1] ^ den_reg[VW];
                qmag_next = '0;
                cnt_next  = CNTW'(IW - 1);
                if (num_mag >= (den_ext << IW)) begin
                    state_next = mtis_pkg::ST_CLAMP;
                end else begin
                    state_next = mtis_pkg::ST_DIV;
                end
            end

            // one quotient bit per cycle
            mtis_pkg::ST_DIV: begin
                if (div_take) begin
                    rem_next = rem_reg - dsh_reg;
                end
                qmag_next = IW'({qmag_reg, div_take});
                dsh_next  = dsh_reg >> 1;
                cnt_next  = cnt_reg - CNTW'(1);
                if (cnt_reg == '0) begin
                    state_next = mtis_pkg::ST_CLAMP;
                end
            end

            mtis_pkg::ST_CLAMP: begin
                mir_next   = s_clamp[IW:1];
                state_next = mtis_pkg::ST_PROBE_A;
            end

            mtis_pkg::ST_PROBE_A: begin
                ram_raddr  = p_lo;
                state_next = mtis_pkg::ST_PROBE_B;
            end

            mtis_pkg::ST_PROBE_B: begin
                vlo_next   = ram_rdata;
                ram_raddr  = p_hi;
                state_next = mtis_pkg::ST_DECIDE;
            end

            // narrow the bounds to the sub-interval that holds the value
            mtis_pkg::ST_DECIDE: begin
                if (precedes(asc_reg, v_reg, vlo_reg)) begin
                    ri_next = p_lo;
                    ar_next = vlo_reg;
                end else if (precedes(asc_reg, ram_rdata, v_reg)) begin
                    li_next = p_hi;
                    al_next = ram_rdata;
                end else begin
                    li_next = p_lo;
                    al_next = vlo_reg;
                    ri_next = p_hi;
                    ar_next = ram_rdata;
                end
                if (IW'(ri_next - li_next) > IW'(1)) begin
                    state_next = mtis_pkg::ST_ROUND;
                end else begin
                    state_next = mtis_pkg::ST_FINISH;
                end
            end

            // hand result to the output register once it is free
            mtis_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    out_next     = li_out[mtis_pkg::START_WIDTH-1:0];
                    state_next   = mtis_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = mtis_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= mtis_pkg::ST_IDLE;
            m_valid_reg <= 1'b0;
            entries_reg <= mtis_pkg::ENTRIES_RESET;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            entries_reg <= entries_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        out_reg  <= out_next;
        v_reg    <= v_next;
        al_reg   <= al_next;
        ar_reg   <= ar_next;
        vlo_reg  <= vlo_next;
        li_reg   <= li_next;
        ri_reg   <= ri_next;
        mib_reg  <= mib_next;
        mir_reg  <= mir_next;
        asc_reg  <= asc_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        dsh_reg  <= dsh_next;
        qmag_reg <= qmag_next;
        sat_reg  <= sat_next;
        qneg_reg <= qneg_next;
        cnt_reg  <= cnt_next;
    end

    assign m_valid          = m_valid_reg;
    assign m_interval_start = out_reg;

endmodule
